### hw/rtl/scancode_set1_key_translator_defines.svh
// Assertion helpers for the scan code translator.
`ifndef SCANCODE_SET1_KEY_TRANSLATOR_DEFINES_SVH
`define SCANCODE_SET1_KEY_TRANSLATOR_DEFINES_SVH

`ifndef SYNTH
`define SCS1_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("scs1 assertion failed");
`define SCS1_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("scs1 assertion failed");
`else
`define SCS1_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define SCS1_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

### hw/rtl/scs1_pkg.sv
package scs1_pkg;

    localparam int unsigned SCAN_W = 8;
    localparam int unsigned CODE_W = 7;
    localparam int unsigned KEY_W  = 5;
    localparam int unsigned CHAR_W = 7;

    localparam int unsigned REL_BIT = 7;

    localparam logic [CODE_W-1:0] SC_LSHIFT = 7'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT = 7'h36;
    localparam logic [CODE_W-1:0] SC_CAPS   = 7'h3A;
    localparam logic [CODE_W-1:0] SC_CTRL   = 7'h1D;
    localparam logic [CODE_W-1:0] SC_ALT    = 7'h38;

    localparam logic [KEY_W-1:0] ID_CHAR = 5'd0;
    localparam logic [KEY_W-1:0] ID_CAPS = 5'd27;
    localparam logic [KEY_W-1:0] ID_CTRL = 5'd28;
    localparam logic [KEY_W-1:0] ID_ALT  = 5'd29;

    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 7'h7A;

    // Decoded event plus flag updates for one item
    typedef struct packed {
        logic              emit;
        logic [KEY_W-1:0]  key_id;
        logic [CHAR_W-1:0] char_code;
        logic              is_press;
        logic              shift_we;
        logic              shift_val;
        logic              caps_toggle;
    } scs1_result_t;

    // Navigation, editing and function keys; 0 when not a named key
    function automatic logic [KEY_W-1:0] named_id(input logic [CODE_W-1:0] code);
        logic [KEY_W-1:0] id;
        unique case (code)
            7'h01:   id = 5'd1;
            7'h0E:   id = 5'd2;
            7'h0F:   id = 5'd3;
            7'h1C:   id = 5'd4;
            7'h39:   id = 5'd5;
            7'h47:   id = 5'd6;
            7'h48:   id = 5'd7;
            7'h49:   id = 5'd8;
            7'h4B:   id = 5'd9;
            7'h4D:   id = 5'd10;
            7'h4F:   id = 5'd11;
            7'h50:   id = 5'd12;
            7'h51:   id = 5'd13;
            7'h53:   id = 5'd14;
            7'h3B:   id = 5'd15;
            7'h3C:   id = 5'd16;
            7'h3D:   id = 5'd17;
            7'h3E:   id = 5'd18;
            7'h3F:   id = 5'd19;
            7'h40:   id = 5'd20;
            7'h41:   id = 5'd21;
            7'h42:   id = 5'd22;
            7'h43:   id = 5'd23;
            7'h44:   id = 5'd24;
            7'h57:   id = 5'd25;
            7'h58:   id = 5'd26;
            default: id = ID_CHAR;
        endcase
        return id;
    endfunction

    // Unshifted character; 0 when not a character key
    function automatic logic [CHAR_W-1:0] plain_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            7'h02: ch = 7'h31;
            7'h03: ch = 7'h32;
            7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;
            7'h06: ch = 7'h35;
            7'h07: ch = 7'h36;
            7'h08: ch = 7'h37;
            7'h09: ch = 7'h38;
            7'h0A: ch = 7'h39;
            7'h0B: ch = 7'h30;
            7'h0C: ch = 7'h2D;
            7'h0D: ch = 7'h3D;
            7'h1A: ch = 7'h5B;
            7'h1B: ch = 7'h5D;
            7'h27: ch = 7'h3B;
            7'h28: ch = 7'h27;
            7'h29: ch = 7'h60;
            7'h2B: ch = 7'h5C;
            7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E;
            7'h35: ch = 7'h2F;
            7'h1E: ch = 7'h61;
            7'h30: ch = 7'h62;
            7'h2E: ch = 7'h63;
            7'h20: ch = 7'h64;
            7'h12: ch = 7'h65;
            7'h21: ch = 7'h66;
            7'h22: ch = 7'h67;
            7'h23: ch = 7'h68;
            7'h17: ch = 7'h69;
            7'h24: ch = 7'h6A;
            7'h25: ch = 7'h6B;
            7'h26: ch = 7'h6C;
            7'h32: ch = 7'h6D;
            7'h31: ch = 7'h6E;
            7'h18: ch = 7'h6F;
            7'h19: ch = 7'h70;
            7'h10: ch = 7'h71;
            7'h13: ch = 7'h72;
            7'h1F: ch = 7'h73;
            7'h14: ch = 7'h74;
            7'h16: ch = 7'h75;
            7'h2F: ch = 7'h76;
            7'h11: ch = 7'h77;
            7'h2D: ch = 7'h78;
            7'h15: ch = 7'h79;
            7'h2C: ch = 7'h7A;
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

    // Shifted character
    function automatic logic [CHAR_W-1:0] shift_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            7'h02: ch = 7'h21;
            7'h03: ch = 7'h40;
            7'h04: ch = 7'h23;
            7'h05: ch = 7'h24;
            7'h06: ch = 7'h25;
            7'h07: ch = 7'h5E;
            7'h08: ch = 7'h26;
            7'h09: ch = 7'h2A;
            7'h0A: ch = 7'h28;
            7'h0B: ch = 7'h29;
            7'h0C: ch = 7'h5F;
            7'h0D: ch = 7'h2B;
            7'h1A: ch = 7'h7B;
            7'h1B: ch = 7'h7D;
            7'h27: ch = 7'h3A;
            7'h28: ch = 7'h22;
            7'h29: ch = 7'h7E;
            7'h2B: ch = 7'h7C;
            7'h33: ch = 7'h3C;
            7'h34: ch = 7'h3E;
            7'h35: ch = 7'h3F;
            7'h1E: ch = 7'h41;
            7'h30: ch = 7'h42;
            7'h2E: ch = 7'h43;
            7'h20: ch = 7'h44;
            7'h12: ch = 7'h45;
            7'h21: ch = 7'h46;
            7'h22: ch = 7'h47;
            7'h23: ch = 7'h48;
            7'h17: ch = 7'h49;
            7'h24: ch = 7'h4A;
            7'h25: ch = 7'h4B;
            7'h26: ch = 7'h4C;
            7'h32: ch = 7'h4D;
            7'h31: ch = 7'h4E;
            7'h18: ch = 7'h4F;
            7'h19: ch = 7'h50;
            7'h10: ch = 7'h51;
            7'h13: ch = 7'h52;
            7'h1F: ch = 7'h53;
            7'h14: ch = 7'h54;
            7'h16: ch = 7'h55;
            7'h2F: ch = 7'h56;
            7'h11: ch = 7'h57;
            7'h2D: ch = 7'h58;
            7'h15: ch = 7'h59;
            7'h2C: ch = 7'h5A;
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

endpackage

### hw/rtl/scs1_decode.sv
module scs1_decode
    import scs1_pkg::*;
(
    input  logic [SCAN_W-1:0] scan,
    input  logic              shift_held,
    input  logic              caps_on,
    output scs1_result_t      res
);

    logic [CODE_W-1:0] code;
    logic              press;
    logic [KEY_W-1:0]  named;
    logic [CHAR_W-1:0] lo_ch;
    logic [CHAR_W-1:0] hi_ch;
    logic              use_hi;

    assign code  = scan[CODE_W-1:0];
    assign press = ~scan[REL_BIT];
    assign named = named_id(code);
    assign lo_ch = plain_char(code);
    assign hi_ch = shift_char(code);

    // letters honour caps lock, everything else only shift
    always_comb
    begin
        if (lo_ch >= CHAR_LOW_A && lo_ch <= CHAR_LOW_Z)
            use_hi = shift_held ^ caps_on;
        else
            use_hi = shift_held;
    end

    always_comb
    begin
        res = '0;
        if (code == SC_LSHIFT || code == SC_RSHIFT)
        begin
            res.shift_we  = 1'b1;
            res.shift_val = press;
        end
        else if (code == SC_CAPS)
        begin
            if (press)
            begin
                res.caps_toggle = 1'b1;
                res.emit        = 1'b1;
                res.key_id      = ID_CAPS;
                res.is_press    = 1'b1;
            end
        end
        else if (code == SC_CTRL)
        begin
            res.emit     = 1'b1;
            res.key_id   = ID_CTRL;
            res.is_press = press;
        end
        else if (code == SC_ALT)
        begin
            res.emit     = 1'b1;
            res.key_id   = ID_ALT;
            res.is_press = press;
        end
        else if (named != ID_CHAR)
        begin
            res.emit     = 1'b1;
            res.key_id   = named;
            res.is_press = press;
        end
        else if (lo_ch != CHAR_NONE && press)
        begin
            res.emit      = 1'b1;
            res.key_id    = ID_CHAR;
            res.char_code = use_hi ? hi_ch : lo_ch;
            res.is_press  = 1'b1;
        end
    end

endmodule

### hw/rtl/scancode_set1_key_translator.sv
// PS/2 set-1 scan byte to key event translator. One scan byte is taken per
// cycle while in_ready is high; its event, if any, reaches the outputs through
// the input register, where the tables decode it, and the result register.
// A byte that gives an event waits in the input register while the result
// register holds an item that has not been taken; bytes that
// give no event (shift, caps release, character release, prefixes, unknown
// codes) never wait and update the flags in order. The shift and caps-lock
// flags are held here; reset clears both.
`include "scancode_set1_key_translator_defines.svh"

module scancode_set1_key_translator
    import scs1_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SCAN_W-1:0] scan_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KEY_W-1:0]  key_id,
    output logic [CHAR_W-1:0] char_code,
    output logic              is_press
);

    logic              in_valid_reg, in_valid_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic              shift_reg, shift_next;
    logic              caps_reg, caps_next;
    logic              out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]  key_id_reg, key_id_next;
    logic [CHAR_W-1:0] char_code_reg, char_code_next;
    logic              is_press_reg, is_press_next;

    scs1_result_t res;
    logic         advance;

    scs1_decode u_decode (
        .scan       (scan_reg),
        .shift_held (shift_reg),
        .caps_on    (caps_reg),
        .res        (res)
    );

    // an item with no event never waits for the result register
    assign advance  = in_valid_reg & (~res.emit | ~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | advance;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        scan_next      = scan_reg;
        shift_next     = shift_reg;
        caps_next      = caps_reg;
        out_valid_next = out_valid_reg;
        key_id_next    = key_id_reg;
        char_code_next = char_code_reg;
        is_press_next  = is_press_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (advance)
        begin
            in_valid_next = 1'b0;
            if (res.shift_we)
                shift_next = res.shift_val;
            if (res.caps_toggle)
                caps_next = ~caps_reg;
            if (res.emit)
            begin
                out_valid_next = 1'b1;
                key_id_next    = res.key_id;
                char_code_next = res.char_code;
                is_press_next  = res.is_press;
            end
        end
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            scan_next     = scan_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            shift_reg     <= 1'b0;
            caps_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            shift_reg     <= shift_next;
            caps_reg      <= caps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg      <= scan_next;
        key_id_reg    <= key_id_next;
        char_code_reg <= char_code_next;
        is_press_reg  <= is_press_next;
    end

    assign out_valid = out_valid_reg;
    assign key_id    = key_id_reg;
    assign char_code = char_code_reg;
    assign is_press  = is_press_reg;

    `SCS1_ASSERT_NEXT(a_caps_flips, clk, rst_n, advance && res.caps_toggle, caps_reg != $past(caps_reg))
    `SCS1_ASSERT_NEXT(a_event_lands, clk, rst_n, advance && res.emit, out_valid_reg)
    `SCS1_ASSERT_NOW(a_named_no_char, clk, rst_n, out_valid_reg && key_id_reg != ID_CHAR, char_code_reg == CHAR_NONE)
    `SCS1_ASSERT_NOW(a_char_is_press, clk, rst_n, out_valid_reg && key_id_reg == ID_CHAR, is_press_reg && char_code_reg != CHAR_NONE)

endmodule
